>>> rtl/windowed_rms_level_meter_defines.svh
// Assertion macros for the windowed RMS level meter checker.
// Used by the checker bound to the top level; needs a clk and rst in scope.
`ifndef WINDOWED_RMS_LEVEL_METER_DEFINES_SVH
`define WINDOWED_RMS_LEVEL_METER_DEFINES_SVH

// Checked on every edge outside reset.
`define WRLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define WRLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/wrlm_pkg.sv
// Shared types and constants for the windowed RMS level meter.
// No dependencies; imported by every module of the block.
package wrlm_pkg;

  localparam int SampleW = 16;
  localparam int RemainW = 12;
  localparam int WinW    = 13;
  localparam int CountW  = 16;
  localparam int SumW    = 48;
  localparam int LevelW  = 15;
  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int QCntW   = QPtrW + 1;

  localparam logic [WinW-1:0]   WinReset    = 13'd128;
  localparam logic [CountW-1:0] CountMax    = 16'hFFFF;
  // full scale is 2^30; floor = 2^30 / 8000
  localparam logic [SumW-1:0]   PowerFloor  = 48'd134217;
  localparam logic [5:0]        FsShift     = 6'd30;
  // 10*log10(2) in Q16
  localparam logic [17:0]       DbPerOctave = 18'd197283;
  localparam logic [LevelW-1:0] LevelMinMag = 15'd10240;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last;
    logic [SumW-1:0]    sum;
    logic [CountW-1:0]  count;
  } wrlm_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wrlm_qstat_t;

endpackage

>>> rtl/wrlm_front.sv
// Front end: window register, input handshake, square-and-accumulate.
// Depends on wrlm_pkg; pushes one entry per accepted sample into the queue.
module wrlm_front #(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wrlm_pkg::WinW-1:0]     window_frames,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wrlm_pkg::SampleW-1:0]  sample_in,
  input  logic [wrlm_pkg::RemainW-1:0]  frames_remaining,
  input  logic                          last_of_block,
  input  wrlm_pkg::wrlm_qstat_t         qstat,
  output logic                          push,
  output wrlm_pkg::wrlm_entry_t         push_entry
);
  import wrlm_pkg::*;

  localparam logic [16:0] MaxWin = 17'(MAX_WINDOW);

  logic [WinW-1:0]    win_reg;
  logic [SumW-1:0]    power_sum;
  logic [CountW-1:0]  sample_count;

  logic [16:0]        win_eff;
  logic               in_window;
  logic [SampleW-1:0] mag;
  logic [31:0]        square;
  logic [SumW-1:0]    sum_next;
  logic [CountW-1:0]  count_next;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign push      = in_valid && !in_stall;

  always_comb begin
    win_eff   = ({4'b0, win_reg} > MaxWin) ? MaxWin : {4'b0, win_reg};
    in_window = ({5'b0, frames_remaining} < win_eff) && (sample_count != CountMax);
    // magnitude of a two's complement sample; most negative value gives 2^15
    mag       = sample_in[SampleW-1] ? (SampleW'(0) - sample_in) : sample_in;
    square    = 32'(mag) * 32'(mag);
    sum_next   = power_sum;
    count_next = sample_count;
    if (in_window) begin
      sum_next   = power_sum + {16'b0, square};
      count_next = sample_count + 16'd1;
    end
    push_entry.sample = sample_in;
    push_entry.last   = last_of_block;
    push_entry.sum    = sum_next;
    push_entry.count  = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg      <= WinReset;
      power_sum    <= '0;
      sample_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_reg <= window_frames;
      end
      if (push) begin
        if (last_of_block) begin
          power_sum    <= '0;
          sample_count <= '0;
        end else begin
          power_sum    <= sum_next;
          sample_count <= count_next;
        end
      end
    end
  end

endmodule

>>> rtl/wrlm_fifo.sv
// Short queue between front and back ends.
// Depends on wrlm_pkg for the entry type and depth.
module wrlm_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  wrlm_pkg::wrlm_entry_t push_entry,
  input  logic                  pop,
  output wrlm_pkg::wrlm_entry_t head,
  output wrlm_pkg::wrlm_qstat_t qstat
);
  import wrlm_pkg::*;

  wrlm_entry_t      slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] fill;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (fill == QCntW'(QDepth));
  assign qstat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/wrlm_back.sv
// Back end: per-block mean (restoring divider), log2 by repeated squaring,
// dB scaling, held level and the output register. Depends on wrlm_pkg.
module wrlm_back (
  input  logic                              clk,
  input  logic                              rst,
  input  wrlm_pkg::wrlm_qstat_t             qstat,
  input  wrlm_pkg::wrlm_entry_t             head,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [wrlm_pkg::SampleW-1:0] sample_out,
  output logic signed [wrlm_pkg::LevelW-1:0]  level_db,
  output logic                              level_updated
);
  import wrlm_pkg::*;

  localparam logic [5:0] DivLast = 6'(SumW - 1);
  localparam logic [5:0] SqLast  = 6'd15;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_CLAMP, ST_NORM, ST_SQ_MUL, ST_SQ_UPD,
    ST_DB_MUL, ST_DB_FIN, ST_DONE
  } state_t;

  state_t                    state;
  logic [SampleW-1:0]        pend_sample;
  logic [SumW-1:0]           quot;
  logic [CountW:0]           rem;
  logic [CountW-1:0]         divisor;
  logic [5:0]                step;
  logic [SumW-1:0]           x;
  logic [5:0]                expo;
  logic [15:0]               frac;
  logic [61:0]               prod;
  logic [38:0]               db_prod;
  logic signed [LevelW-1:0]  held_level;

  logic              out_free;
  logic [CountW:0]   rem_sh;
  logic              rem_ge;
  logic [31:0]       sq_top;
  logic [20:0]       neg_log;
  logic [38:0]       db_rnd;
  logic [LevelW-1:0] db_mag;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && !qstat.empty && out_free;

  always_comb begin
    rem_sh  = {rem[CountW-1:0], quot[SumW-1]};
    rem_ge  = rem_sh >= {1'b0, divisor};
    sq_top  = prod[61:30];
    // -(log2(mean) - 30) in Q16, valid while expo < 30
    neg_log = {5'(FsShift - expo), 16'b0} - {5'b0, frac};
    db_rnd  = db_prod + 39'(1 << 23);
    db_mag  = (db_rnd[38:24] > LevelMinMag) ? LevelMinMag : db_rnd[38:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      held_level <= '0;
      step       <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            if (!head.last) begin
              out_valid     <= 1'b1;
              sample_out    <= head.sample;
              level_db      <= held_level;
              level_updated <= 1'b0;
            end else begin
              pend_sample <= head.sample;
              divisor     <= head.count;
              rem         <= '0;
              step        <= '0;
              if (head.count == '0) begin
                quot  <= '0;
                state <= ST_CLAMP;
              end else begin
                quot  <= head.sum;
                state <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          rem  <= rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
          quot <= {quot[SumW-2:0], rem_ge};
          step <= step + 6'd1;
          if (step == DivLast) state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          x     <= (quot < PowerFloor) ? PowerFloor : quot;
          expo  <= FsShift;
          state <= ST_NORM;
        end
        ST_NORM: begin
          // one bit a cycle until the leading one sits at bit 30
          if (x[SumW-1:31] != '0) begin
            x    <= x >> 1;
            expo <= expo + 6'd1;
          end else if (!x[30]) begin
            x    <= x << 1;
            expo <= expo - 6'd1;
          end else begin
            frac  <= '0;
            step  <= '0;
            state <= ST_SQ_MUL;
          end
        end
        ST_SQ_MUL: begin
          prod  <= 62'(x[30:0]) * 62'(x[30:0]);
          state <= ST_SQ_UPD;
        end
        ST_SQ_UPD: begin
          if (sq_top[31]) begin
            x    <= SumW'(sq_top[31:1]);
            frac <= {frac[14:0], 1'b1};
          end else begin
            x    <= SumW'(sq_top[30:0]);
            frac <= {frac[14:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == SqLast) state <= ST_DB_MUL;
          else                state <= ST_SQ_MUL;
        end
        ST_DB_MUL: begin
          // mean at or above full scale reads 0 dB
          if (expo >= FsShift) db_prod <= '0;
          else                 db_prod <= 39'(neg_log) * 39'(DbPerOctave);
          state <= ST_DB_FIN;
        end
        ST_DB_FIN: begin
          held_level <= $signed(LevelW'(0) - db_mag);
          state      <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            sample_out    <= pend_sample;
            level_db      <= held_level;
            level_updated <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/windowed_rms_level_meter.sv
// Channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// cfg      | cfg_valid / cfg_ready | window_frames (13b, trailing frames measured)
// in       | in_valid / in_stall   | sample_in, frames_remaining, last_of_block
// out      | out_valid / out_stall | sample_out, level_db (Q7.8), level_updated
//
// A sample that does not end a block passes through a queue slot and the output
//   register; with no stall samples stream at one per cycle.
// An end-of-block sample goes in the back end through 48 bit-serial divider steps
//   (skipped when the window is empty), up to 17 normalize steps, 16 squarings on
//   the one 31x31 multiplier (a multiply state and an update state each), then
//   scale and round.
// The 4-entry queue lets the front keep taking samples during that time.
// Reset (rst, synchronous) sets the window register to 128, clears the running sum,
//   count and held level (0 dB). No clearing pass.
// in_stall rises only when the queue is full; out_stall holds the output reg.
//
// Top level of the windowed RMS level meter; depends on wrlm_pkg,
// wrlm_front, wrlm_fifo and wrlm_back.
module windowed_rms_level_meter #(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wrlm_pkg::WinW-1:0]           window_frames,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [wrlm_pkg::SampleW-1:0] sample_in,
  input  logic [wrlm_pkg::RemainW-1:0]        frames_remaining,
  input  logic                                last_of_block,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [wrlm_pkg::SampleW-1:0] sample_out,
  output logic signed [wrlm_pkg::LevelW-1:0]  level_db,
  output logic                                level_updated
);
  import wrlm_pkg::*;

  logic        push;
  logic        pop;
  wrlm_entry_t push_entry;
  wrlm_entry_t head;
  wrlm_qstat_t qstat;

  // front: window compare, square, running sum; snapshot rides the queue
  wrlm_front #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .window_frames    (window_frames),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample_in        (sample_in),
    .frames_remaining (frames_remaining),
    .last_of_block    (last_of_block),
    .qstat            (qstat),
    .push             (push),
    .push_entry       (push_entry)
  );

  wrlm_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // back: mean, log, dB, held level, output register
  wrlm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample_out    (sample_out),
    .level_db      (level_db),
    .level_updated (level_updated)
  );

endmodule

>>> rtl/wrlm_checker.sv
// Port-level checker for the windowed RMS level meter, bound to the top.
// Depends on wrlm_pkg and windowed_rms_level_meter_defines.svh.
`include "windowed_rms_level_meter_defines.svh"

module wrlm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [wrlm_pkg::SampleW-1:0] sample_out,
  input logic signed [wrlm_pkg::LevelW-1:0]  level_db,
  input logic                                level_updated
);
  import wrlm_pkg::*;

  localparam logic signed [LevelW-1:0] LevelLow = LevelW'(-$signed({1'b0, LevelMinMag}));

  logic signed [LevelW-1:0] last_level;
  logic                     out_take;
  logic                     out_wait;
  logic                     plain_take;
  logic                     level_ok;

  assign out_take   = out_valid && !out_stall;
  assign out_wait   = out_valid && out_stall;
  assign plain_take = out_take && !level_updated;
  assign level_ok   = (level_db <= 0) && (level_db >= LevelLow);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= '0;
    end else if (out_take) begin
      last_level <= level_db;
    end
  end

  `WRLM_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "output valid right after reset")
  `WRLM_ASSERT(a_out_hold, out_wait |=> out_valid && $stable(sample_out), "stalled output moved")
  `WRLM_ASSERT(a_level_held, plain_take |-> level_db == last_level, "level changed mid-block")
  `WRLM_ASSERT(a_level_range, out_valid |-> level_ok, "level out of range")

endmodule

bind windowed_rms_level_meter wrlm_checker u_wrlm_checker (.*);
